/* hw/rtl/sts_pkg.sv */
// ============================================================================
// sts_pkg
// Types, codes and character classes shared by the script token scanner.
// ============================================================================
`default_nettype none

package sts_pkg;

   // Scanner modes.
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_INT    = 3'd1,
      MODE_FRAC   = 3'd2,
      MODE_IDENT  = 3'd3,
      MODE_STRING = 3'd4
   } mode_type;

   // Token type codes carried on a token-end word.
   localparam logic [3:0] TOK_INT     = 4'd0;
   localparam logic [3:0] TOK_FLOAT   = 4'd1;
   localparam logic [3:0] TOK_IDENT   = 4'd2;
   localparam logic [3:0] TOK_STRING  = 4'd3;
   localparam logic [3:0] TOK_UNKNOWN = 4'd4;
   localparam logic [3:0] TOK_EOF     = 4'd5;
   localparam logic [3:0] TOK_KW0     = 4'd6;

   // Word kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int IdentChars = 6;
   localparam int NumKw      = 8;

   // Entries in the result queue of the top level.
   localparam int QDepth     = 4;

   // Keyword text, bytes reversed so the first character sits in the low byte.
   localparam logic [47:0] KW_TEXT [NumKw] = '{
      48'("fi"), 48'("esle"), 48'("fed"), 48'("nruter"),
      48'("elihw"), 48'("eurT"), 48'("eslaF"), 48'("enoN")
   };
   localparam logic [2:0] KW_LEN [NumKw] = '{
      3'd2, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5, 3'd4
   };

   // One result word.
   typedef struct packed {
      logic       last;
      logic [3:0] token_type;
      logic [7:0] char_res;
      logic       kind;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
             (c == 8'h0D);
   endfunction

   // Type of an ended identifier: a keyword code on an exact match, else ident.
   function automatic logic [3:0] ident_type(input logic [47:0] chars,
                                             input logic [2:0] len);
      logic [3:0] t;
      logic       same;
      t = TOK_IDENT;
      for (int k = NumKw - 1; k >= 0; k--) begin
         same = (KW_LEN[k] == len);
         for (int i = 0; i < IdentChars; i++) begin
            if ((3'(i) < len) && (chars[8*i +: 8] != KW_TEXT[k][8*i +: 8])) begin
               same = 1'b0;
            end
         end
         if (same) begin
            t = 4'(TOK_KW0 + 4'(k));
         end
      end
      return t;
   endfunction

   function automatic result_type char_word(input logic [7:0] c);
      result_type r;
      r.kind       = KIND_CHAR;
      r.char_res   = c;
      r.token_type = TOK_INT;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic result_type end_word(input logic [3:0] t);
      result_type r;
      r.kind       = KIND_END;
      r.char_res   = 8'd0;
      r.token_type = t;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/script_token_scanner_top.sv */
// ============================================================================
// script_token_scanner_top: byte-serial scanner for a small script language.
// A byte's result words enter the result queue as it is taken and leave on rsp.
// Bytes are taken one per cycle while the queue has room for two more words; a
// byte giving two words shares the single output port, absorbed by the four-entry result queue.
// Reset (synchronous) returns the scanner to between tokens, queue empty.
// ============================================================================
`default_nettype none

module script_token_scanner_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_req
   input  wire logic        req_tlast,   // is_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] char_res, [11:8] token_type, zero fill
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast    // last
);

   // Scanner state.
   sts_pkg::mode_type mode_ff, mode_in;
   logic              dot_ff, dot_in;
   logic              dq_ff, dq_in;
   logic              stop_ff, stop_in;
   logic [2:0]        len_ff, len_in;
   logic [7:0]        chars_ff [sts_pkg::IdentChars];
   logic              chr_we;
   logic [2:0]        chr_idx;
   logic [47:0]       chars_packed;

   // Result words of the current byte.
   sts_pkg::result_type res0, res1;
   logic [1:0]          nres;
   logic                start;
   logic [7:0]          c;
   logic                fire;

   // Result queue.
   sts_pkg::result_type q_ff [sts_pkg::QDepth];
   logic [1:0]          wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic                pop;

   assign c    = req_tdata;
   assign fire = req_tvalid && req_tready;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      for (int i = 0; i < sts_pkg::IdentChars; i++) begin
         chars_packed[8*i +: 8] = chars_ff[i];
      end
   end

   // Next scanner state and the words this byte yields.
   always_comb begin
      sts_pkg::result_type w [2];
      logic [1:0]          n;
      w[0]    = sts_pkg::end_word(sts_pkg::TOK_EOF);
      w[1]    = sts_pkg::end_word(sts_pkg::TOK_EOF);
      n       = 2'd0;
      mode_in = mode_ff;
      dot_in  = dot_ff;
      dq_in   = dq_ff;
      stop_in = stop_ff;
      len_in  = len_ff;
      chr_we  = 1'b0;
      chr_idx = len_ff;
      start   = 1'b0;

      if (stop_ff) begin
         if (req_tlast) begin
            stop_in = 1'b0;
            mode_in = sts_pkg::MODE_IDLE;
            dot_in  = 1'b0;
         end
      end else if (req_tlast) begin
         // End of source closes any open token, then EOF.
         case (mode_ff)
            sts_pkg::MODE_INT: begin
               w[n[0]] = sts_pkg::end_word(sts_pkg::TOK_INT);
               n       = n + 2'd1;
            end
            sts_pkg::MODE_FRAC: begin
               w[n[0]] = sts_pkg::end_word(sts_pkg::TOK_FLOAT);
               n       = n + 2'd1;
            end
            sts_pkg::MODE_IDENT: begin
               w[n[0]] = sts_pkg::end_word(sts_pkg::ident_type(chars_packed, len_ff));
               n       = n + 2'd1;
            end
            sts_pkg::MODE_STRING: begin
               w[n[0]] = sts_pkg::end_word(sts_pkg::TOK_UNKNOWN);
               n       = n + 2'd1;
            end
            default: begin
            end
         endcase
         w[n[0]] = sts_pkg::end_word(sts_pkg::TOK_EOF);
         n       = n + 2'd1;
         mode_in = sts_pkg::MODE_IDLE;
         dot_in  = 1'b0;
      end else begin
         case (mode_ff)
            sts_pkg::MODE_INT: begin
               if (dot_ff) begin
                  if (sts_pkg::is_digit(c)) begin
                     w[0]    = sts_pkg::char_word(".");
                     w[1]    = sts_pkg::char_word(c);
                     n       = 2'd2;
                     dot_in  = 1'b0;
                     mode_in = sts_pkg::MODE_FRAC;
                  end else begin
                     // The held dot acts as a stray byte and stops the stream.
                     w[0]    = sts_pkg::end_word(sts_pkg::TOK_INT);
                     w[1]    = sts_pkg::end_word(sts_pkg::TOK_EOF);
                     n       = 2'd2;
                     mode_in = sts_pkg::MODE_IDLE;
                     dot_in  = 1'b0;
                     stop_in = 1'b1;
                  end
               end else if (sts_pkg::is_digit(c)) begin
                  w[0] = sts_pkg::char_word(c);
                  n    = 2'd1;
               end else if (c == ".") begin
                  dot_in = 1'b1;
               end else begin
                  w[0]  = sts_pkg::end_word(sts_pkg::TOK_INT);
                  n     = 2'd1;
                  start = 1'b1;
               end
            end
            sts_pkg::MODE_FRAC: begin
               if (sts_pkg::is_digit(c)) begin
                  w[0] = sts_pkg::char_word(c);
                  n    = 2'd1;
               end else begin
                  w[0]  = sts_pkg::end_word(sts_pkg::TOK_FLOAT);
                  n     = 2'd1;
                  start = 1'b1;
               end
            end
            sts_pkg::MODE_IDENT: begin
               if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c) || (c == "_")) begin
                  chr_we = (len_ff < 3'd6);
                  if (len_ff < 3'd7) begin
                     len_in = len_ff + 3'd1;
                  end
                  w[0] = sts_pkg::char_word(c);
                  n    = 2'd1;
               end else begin
                  w[0]  = sts_pkg::end_word(sts_pkg::ident_type(chars_packed, len_ff));
                  n     = 2'd1;
                  start = 1'b1;
               end
            end
            sts_pkg::MODE_STRING: begin
               if (c == (dq_ff ? 8'h22 : 8'h27)) begin
                  w[0]    = sts_pkg::end_word(sts_pkg::TOK_STRING);
                  n       = 2'd1;
                  mode_in = sts_pkg::MODE_IDLE;
               end else begin
                  w[0] = sts_pkg::char_word(c);
                  n    = 2'd1;
               end
            end
            default: begin
               start = 1'b1;
            end
         endcase

         // Handle the byte as between tokens; it may open a new token.
         if (start) begin
            mode_in = sts_pkg::MODE_IDLE;
            dot_in  = 1'b0;
            if (sts_pkg::is_blank(c)) begin
               mode_in = sts_pkg::MODE_IDLE;
            end else if (sts_pkg::is_digit(c)) begin
               mode_in = sts_pkg::MODE_INT;
               w[n[0]] = sts_pkg::char_word(c);
               n       = n + 2'd1;
            end else if (sts_pkg::is_alpha(c) || (c == "_")) begin
               mode_in = sts_pkg::MODE_IDENT;
               chr_we  = 1'b1;
               chr_idx = 3'd0;
               len_in  = 3'd1;
               w[n[0]] = sts_pkg::char_word(c);
               n       = n + 2'd1;
            end else if ((c == 8'h27) || (c == 8'h22)) begin
               mode_in = sts_pkg::MODE_STRING;
               dq_in   = (c == 8'h22);
            end else begin
               w[n[0]] = sts_pkg::end_word(sts_pkg::TOK_EOF);
               n       = n + 2'd1;
               stop_in = 1'b1;
            end
         end
      end

      res0      = w[0];
      res1      = w[1];
      res0.last = (n == 2'd1);
      res1.last = (n == 2'd2);
      nres      = n;
   end

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sts_pkg::MODE_IDLE;
         dot_ff  <= 1'b0;
         dq_ff   <= 1'b0;
         stop_ff <= 1'b0;
         len_ff  <= 3'd0;
      end else if (fire) begin
         mode_ff <= mode_in;
         dot_ff  <= dot_in;
         dq_ff   <= dq_in;
         stop_ff <= stop_in;
         len_ff  <= len_in;
      end
   end

   // Identifier character store.
   always_ff @(posedge clock) begin
      for (int i = 0; i < sts_pkg::IdentChars; i++) begin
         if (fire && chr_we && (chr_idx == 3'(i))) begin
            chars_ff[i] <= c;
         end
      end
   end

   // Result queue pointers and fill count.
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (fire) begin
         wp_in  = wp_ff + nres;
         cnt_in = cnt_ff + {1'b0, nres};
      end
      if (pop) begin
         rp_in  = rp_ff + 2'd1;
         cnt_in = cnt_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage: up to two words written per accepted byte.
   always_ff @(posedge clock) begin
      if (fire && (nres != 2'd0)) begin
         q_ff[wp_ff] <= res0;
      end
      if (fire && (nres == 2'd2)) begin
         q_ff[2'(wp_ff + 2'd1)] <= res1;
      end
   end

   // Room for two more words is needed before a byte is taken.
   assign req_tready = (cnt_ff <= 3'(sts_pkg::QDepth - 2));
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = {4'd0, q_ff[rp_ff].token_type, q_ff[rp_ff].char_res};
   assign rsp_tuser  = q_ff[rp_ff].kind;
   assign rsp_tlast  = q_ff[rp_ff].last;

endmodule

`default_nettype wire
